[rtl/bsc_pkg.sv]
// Package: shared constants, types and register indexes for the compensation block.
`default_nettype none
package bsc_pkg;
    localparam logic [2:0] REG_CAL_A  = 3'd0;
    localparam logic [2:0] REG_CAL_B  = 3'd1;
    localparam logic [2:0] REG_CAL_C  = 3'd2;
    localparam logic [2:0] REG_OSS    = 3'd3;
    localparam logic [2:0] REG_TARGET = 3'd4;
    localparam logic [2:0] REG_TOFS   = 3'd5;
    localparam logic [16:0] TARGET_RESET = 17'd101400;
    localparam logic [15:0] TOFS_RESET   = 16'hFB90;
    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFFE343;
    localparam logic [31:0] C_3791  = 32'd3791;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_50000 = 32'd50000;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_STEP = 7'b0001000,
        ST_OUT  = 7'b0010000,
        ST_FLT  = 7'b0100000,
        ST_SETP = 7'b1000000
    } state_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

[rtl/barometric_sensor_compensation.sv]
// Top level: serial-datapath barometric temperature and pressure compensation.
//
// Channels: s_ (temperature_raw, pressure_bytes) in, m_ (temperature_out,
// pressure_out, divide_fault) out, cfg_ register writes, all valid/ready.
// One transaction at a time runs through a micro-sequenced datapath with a
// shift-add multiplier (one bit per cycle) and a restoring divider (one
// quotient bit per cycle). An item runs 15 steps: 11 products and 2
// quotients plus short ALU steps; s_ready is high only when idle, so a new
// item is taken only after the one before it has presented its result.
// A zero divisor, for temperature or for pressure, ends the item early with
// divide_fault and zero results.
// A new item may be taken while a result waits; it holds before the result
// stage until the result register is free, so a stall adds its length.
// cfg_ready is high only while idle with no result pending.
// Reset (aresetn low, synchronous) restores register defaults, sets the
// first-reading flag and clears the pressure trim; no clearing pass.
`default_nettype none
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_temperature_raw,
    input  wire logic [23:0] s_pressure_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_temperature_out,
    output logic [31:0]      m_pressure_out,
    output logic             m_divide_fault,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] cal_a_reg, cal_b_reg;
    logic [47:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic [16:0] target_reg;
    logic [15:0] tofs_reg;
    logic        first_reg;
    logic [31:0] trim_reg;
    state_t      state_reg;
    logic [3:0]  pc_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] ut_reg;
    logic [23:0] upb_reg;
    // working registers
    logic [31:0] x1_reg, b5_reg, b6_reg, sq_reg, b3_reg, b4_reg, p_reg;
    // serial unit: a = multiplicand / divisor, b = multiplier / dividend
    logic [31:0] a_reg, b_reg, acc_reg;
    logic [15:0] tout_reg;
    logic [31:0] pout_reg;
    logic        flt_reg;

    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = cal_a_reg[63:48]; assign ac2 = cal_a_reg[47:32];
    assign ac3 = cal_a_reg[31:16]; assign ac4 = cal_a_reg[15:0];
    assign ac5 = cal_b_reg[63:48]; assign ac6 = cal_b_reg[47:32];
    assign b1  = cal_b_reg[31:16]; assign b2  = cal_b_reg[15:0];
    assign mc  = cal_c_reg[31:16]; assign md  = cal_c_reg[15:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid;
    assign m_temperature_out = tout_reg;
    assign m_pressure_out    = pout_reg;
    assign m_divide_fault    = flt_reg;

    // divider step: partial remainder in acc, dividend bits shift out of b
    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {acc_reg, b_reg[31]};
    assign rem_sub = rem_sh - {1'b0, a_reg};

    logic m_valid_reg;
    assign m_valid = m_valid_reg;

    // helpers for step values
    logic [31:0] up, b7, bsum, ac1x4;
    logic [33:0] tsum;
    assign up    = {8'd0, upb_reg} >> (4'd8 - {2'd0, oss_reg});
    assign ac1x4 = sx16(ac1) << 2;
    assign bsum  = x1_reg + sq_reg;
    assign tsum  = {{2{b5_reg[31]}}, b5_reg} + 34'sd8 + {{18{tofs_reg[15]}}, tofs_reg};
    assign b7    = acc_reg;

    // signed-divide helpers; the divisor comes from the product just finished
    logic [31:0] num_s, den_s, den_v;
    assign num_s = sx16(mc) << 11;
    assign den_v = asr32(acc_reg, 5'd15) + sx16(md);
    assign den_s = den_v[31] ? -den_v : den_v;

    logic [31:0] q_fix;
    logic        q_neg_reg;
    assign q_fix = q_neg_reg ? -b_reg : b_reg;

    // start a multiply or divide of a and b
    logic        go_mul, go_div;
    logic [31:0] ld_a, ld_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0; cal_b_reg <= '0; cal_c_reg <= '0; oss_reg <= '0;
            target_reg <= TARGET_RESET; tofs_reg <= TOFS_RESET;
            first_reg <= 1'b1; trim_reg <= '0;
            state_reg <= ST_IDLE; pc_reg <= '0; cnt_reg <= '0;
            m_valid_reg <= 1'b0; q_neg_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_CAL_A:  cal_a_reg  <= cfg_data;
                    REG_CAL_B:  cal_b_reg  <= cfg_data;
                    REG_CAL_C:  cal_c_reg  <= cfg_data[47:0];
                    REG_OSS:    oss_reg    <= cfg_data[1:0];
                    REG_TARGET: target_reg <= cfg_data[16:0];
                    REG_TOFS:   tofs_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    ut_reg <= s_temperature_raw; upb_reg <= s_pressure_bytes;
                    pc_reg <= '0; state_reg <= ST_STEP;
                end
                ST_MUL: begin
                    // one multiplier bit per cycle, LSB first
                    if (b_reg[0]) acc_reg <= acc_reg + a_reg;
                    a_reg <= a_reg << 1; b_reg <= b_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) state_reg <= ST_STEP;
                end
                ST_DIV: begin
                    // one quotient bit per cycle, MSB first
                    if (!rem_sub[32]) begin
                        acc_reg <= rem_sub[31:0];
                        b_reg <= {b_reg[30:0], 1'b1};
                    end else begin
                        acc_reg <= rem_sh[31:0];
                        b_reg <= {b_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    cnt_reg <= '0; acc_reg <= '0;
                    pc_reg <= pc_reg + 4'd1;
                    if (go_mul) begin
                        a_reg <= ld_a; b_reg <= ld_b; state_reg <= ST_MUL;
                    end
                    if (go_div) begin
                        a_reg <= ld_a; b_reg <= ld_b; state_reg <= ST_DIV;
                    end
                    unique case (pc_reg)
                        4'd0: ;
                        4'd1: begin
                            x1_reg <= asr32(acc_reg, 5'd15);
                            if (den_v == '0)
                                state_reg <= ST_FLT;
                            q_neg_reg <= num_s[31] ^ den_v[31];
                        end
                        4'd2: begin
                            b5_reg <= x1_reg + q_fix;
                            b6_reg <= x1_reg + q_fix - C_4000;
                        end
                        4'd3: sq_reg <= asr32(acc_reg, 5'd12);
                        4'd4: x1_reg <= asr32(acc_reg, 5'd11);
                        4'd5: begin
                            b3_reg <= asr32(((ac1x4 + x1_reg + asr32(acc_reg, 5'd11))
                                << oss_reg) + 32'd2, 5'd2);
                        end
                        4'd6: x1_reg <= asr32(acc_reg, 5'd13);
                        4'd7: ;
                        4'd8: begin
                            b4_reg <= acc_reg >> 15;
                            if ((acc_reg >> 15) == '0) state_reg <= ST_FLT;
                        end
                        4'd9: begin
                            x1_reg <= b7;
                            if (!b7[31]) b_reg <= b7 << 1;
                        end
                        4'd10: p_reg <= x1_reg[31] ? (b_reg << 1) : b_reg;
                        4'd11: x1_reg <= acc_reg;
                        4'd12: x1_reg <= asr32(acc_reg, 5'd16);
                        4'd13: sq_reg <= asr32(acc_reg, 5'd16);
                        default: begin
                            state_reg <= ST_SETP;
                            p_reg <= p_reg + asr32(bsum + C_3791, 5'd4);
                        end
                    endcase
                end
                ST_SETP: if (!m_valid_reg) begin
                    // latch trim on first good reading and present result
                    if (first_reg) begin
                        trim_reg <= {15'd0, target_reg} - p_reg;
                        first_reg <= 1'b0;
                        pout_reg <= {15'd0, target_reg};
                    end else begin
                        pout_reg <= p_reg + trim_reg;
                    end
                    if ($signed(tsum) > 34'sd32767) tout_reg <= 16'h7FFF;
                    else if ($signed(tsum) < -34'sd32768) tout_reg <= 16'h8000;
                    else tout_reg <= tsum[15:0];
                    flt_reg <= 1'b0; state_reg <= ST_OUT;
                end
                ST_FLT: if (!m_valid_reg) begin
                    tout_reg <= '0; pout_reg <= '0; flt_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1; state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // quotient of the pressure divide, doubled when b7 had its top bit set
    function automatic logic [31:0] b7_q(input logic [31:0] q);
        return x1_reg[31] ? (q << 1) : q;
    endfunction

    // operand selection for the serial unit at each step
    always_comb begin
        go_mul = 1'b0; go_div = 1'b0; ld_a = '0; ld_b = '0;
        if (state_reg == ST_STEP) begin
            unique case (pc_reg)
                4'd0: begin go_mul = 1'b1; ld_a = {16'd0, ut_reg} - {16'd0, ac6};
                    ld_b = {16'd0, ac5}; end
                4'd1: begin go_div = (den_v != '0); ld_a = den_s;
                    ld_b = num_s[31] ? -num_s : num_s; end
                4'd2: begin go_mul = 1'b1; ld_a = x1_reg + q_fix - C_4000;
                    ld_b = x1_reg + q_fix - C_4000; end
                4'd3: begin go_mul = 1'b1; ld_a = sx16(b2); ld_b = asr32(acc_reg, 5'd12); end
                4'd4: begin go_mul = 1'b1; ld_a = sx16(ac2); ld_b = b6_reg; end
                4'd5: begin go_mul = 1'b1; ld_a = sx16(ac3); ld_b = b6_reg; end
                4'd6: begin go_mul = 1'b1; ld_a = sx16(b1); ld_b = sq_reg; end
                4'd7: begin go_mul = 1'b1; ld_a = {16'd0, ac4};
                    ld_b = asr32(x1_reg + asr32(acc_reg, 5'd16) + 32'd2, 5'd2) + C_32768; end
                4'd8: begin go_mul = ((acc_reg >> 15) != '0); ld_a = up - b3_reg;
                    ld_b = C_50000 >> oss_reg; end
                4'd9: begin go_div = 1'b1; ld_a = b4_reg;
                    ld_b = b7[31] ? b7 : (b7 << 1); end
                4'd10: begin go_mul = 1'b1;
                    ld_a = asr32(b7_q(b_reg), 5'd8); ld_b = asr32(b7_q(b_reg), 5'd8); end
                4'd11: begin go_mul = 1'b1; ld_a = acc_reg; ld_b = C_3038; end
                4'd12: begin go_mul = 1'b1; ld_a = C_M7357; ld_b = p_reg; end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/bsc_checker.sv]
// Checker: port-level properties of the compensation block, bound to the top level.
`default_nettype none
module bsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_temperature_out,
    input wire logic [31:0] m_pressure_out,
    input wire logic        m_divide_fault,
    input wire logic        cfg_ready
);
    // a pending result holds its pressure payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure_out))
        else $error("result dropped or changed while stalled");
    // faults give zero results
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_fault |-> m_pressure_out == '0 && m_temperature_out == '0)
        else $error("fault with nonzero result");
    // no register write while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !cfg_ready)
        else $error("configuration ready while result pending");
    // an accepted item keeps the input closed in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while busy");
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
`default_nettype wire
